>>> rtl/cbm_pkg.sv
// Shared types, codes and helpers for the cartridge bank mapper.
// Used by cbm_regs, cbm_lookup and cartridge_bank_mapper_scanline_irq.
`timescale 1ns / 1ps

package cbm_pkg;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_TICK       = 2'd1,
    OP_CPU_LOOKUP = 2'd2,
    OP_PPU_LOOKUP = 2'd3
  } op_t;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_PAGES = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_PAGES = 4'd1;
  localparam logic [CFG_DATA_W-1:0]  PRG_PAGES_RESET = 4'd1;
  localparam logic [CFG_DATA_W-1:0]  CHR_PAGES_RESET = 4'd3;

  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned PRG_PAGE_BITS = 13;
  localparam int unsigned CHR_PAGE_BITS = 10;

  // Decoded register addresses.
  localparam logic [15:0] ADDR_PRG_FIRST = 16'h8000;
  localparam logic [15:0] ADDR_PRG_LAST  = 16'h8002;
  localparam logic [15:0] ADDR_CHR_FIRST = 16'hA000;
  localparam logic [15:0] ADDR_CHR_LAST  = 16'hA007;
  localparam logic [15:0] ADDR_IRQ_FIRST = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_LAST  = 16'hC003;
  localparam logic [15:0] ADDR_IRQ_EN    = 16'hE000;

  localparam logic [8:0] COUNTER_MAX = 9'd511;
  localparam logic [7:0] FIXED_BANK  = 8'hFF;

  typedef struct packed {
    logic [2:0][7:0] prg;
    logic [7:0][7:0] chr;
  } bank_state_t;

  // Page mask for a log2 page count; anything above 8 acts as 8.
  function automatic logic [7:0] page_mask(input logic [CFG_DATA_W-1:0] log2v);
    logic [3:0] n;
    logic [8:0] m;
    n = (log2v > 4'd8) ? 4'd8 : log2v;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

endpackage

>>> rtl/cartridge_bank_mapper_scanline_irq.sv
// Cartridge bank mapper with a scanline-matched interrupt.
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while results are taken; a held result stalls
// the input only when both registers are full.
// Reset (rst, synchronous): both stages empty, bank registers, interrupt state,
// line counter and page-count registers return to their power-up values.
`timescale 1ns / 1ps

module cartridge_bank_mapper_scanline_irq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic [15:0]                      address,
  input  logic [7:0]                       value,
  input  logic                             vblank,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             irq_fire,
  output logic [20:0]                      rom_offset,
  output logic                             offset_valid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                           s1_valid;
  cbm_pkg::op_t                   s1_op;
  logic [15:0]                    s1_address;
  logic [7:0]                     s1_value;
  logic                           s1_vblank;
  logic                           advance;
  logic [cbm_pkg::CFG_DATA_W-1:0] prg_pages_log2;
  logic [cbm_pkg::CFG_DATA_W-1:0] chr_pages_log2;
  cbm_pkg::bank_state_t           banks;
  logic                           fire;
  logic [cbm_pkg::OFFSET_W-1:0]   offset;
  logic                           offset_ok;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_pages_log2 <= cbm_pkg::PRG_PAGES_RESET;
      chr_pages_log2 <= cbm_pkg::CHR_PAGES_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == cbm_pkg::CFG_PRG_PAGES) begin
        prg_pages_log2 <= cfg_data;
      end
      if (cfg_index == cbm_pkg::CFG_CHR_PAGES) begin
        chr_pages_log2 <= cfg_data;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op      <= cbm_pkg::op_t'(op);
      s1_address <= address;
      s1_value   <= value;
      s1_vblank  <= vblank;
    end
  end

  cbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .op      (s1_op),
    .address (s1_address),
    .value   (s1_value),
    .vblank  (s1_vblank),
    .banks   (banks),
    .fire    (fire)
  );

  cbm_lookup u_lookup (
    .op             (s1_op),
    .address        (s1_address),
    .banks          (banks),
    .prg_pages_log2 (prg_pages_log2),
    .chr_pages_log2 (chr_pages_log2),
    .offset         (offset),
    .offset_ok      (offset_ok)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq_fire     <= fire;
      rom_offset   <= offset;
      offset_valid <= offset_ok;
    end
  end

  a_fire_not_lookup: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_fire |-> !offset_valid)
    else $error("interrupt pulse on a lookup result");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !offset_valid |-> rom_offset == '0)
    else $error("nonzero offset on a non-lookup result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item left the input register but no result appeared");

endmodule

>>> rtl/cbm_regs.sv
// Bank registers, interrupt enables and the scanline counter.
// Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  cbm_pkg::op_t        op,
  input  logic [15:0]         address,
  input  logic [7:0]          value,
  input  logic                vblank,
  output cbm_pkg::bank_state_t banks,
  output logic                fire
);

  logic [7:0] irq_target_line;
  logic       irq_armed;
  logic       irq_allowed;
  logic [8:0] line_counter;

  logic is_write, is_tick, hit_prg, hit_chr, hit_irq, hit_en;

  assign is_write = (op == cbm_pkg::OP_WRITE);
  assign is_tick  = (op == cbm_pkg::OP_TICK);
  assign hit_prg  = (address >= cbm_pkg::ADDR_PRG_FIRST) && (address <= cbm_pkg::ADDR_PRG_LAST);
  assign hit_chr  = (address >= cbm_pkg::ADDR_CHR_FIRST) && (address <= cbm_pkg::ADDR_CHR_LAST);
  assign hit_irq  = (address >= cbm_pkg::ADDR_IRQ_FIRST) && (address <= cbm_pkg::ADDR_IRQ_LAST);
  assign hit_en   = (address == cbm_pkg::ADDR_IRQ_EN);

  // A vblank tick never fires.
  assign fire = is_tick && !vblank && irq_armed && irq_allowed
                && (line_counter == {1'b0, irq_target_line});

  always_ff @(posedge clk) begin
    if (rst) begin
      banks.prg[0]    <= 8'd0;
      banks.prg[1]    <= 8'd1;
      banks.prg[2]    <= 8'd254;
      for (int i = 0; i < 8; i++) begin
        banks.chr[i] <= 8'(i);
      end
      irq_target_line <= 8'd0;
      irq_armed       <= 1'b0;
      irq_allowed     <= 1'b1;
      line_counter    <= 9'd0;
    end else if (step) begin
      if (is_write) begin
        if (hit_prg) begin
          banks.prg[address[1:0]] <= value;
        end
        if (hit_chr) begin
          banks.chr[address[2:0]] <= value;
        end
        if (hit_irq) begin
          irq_target_line <= value;
          irq_armed       <= (value != 8'd0);
        end
        if (hit_en) begin
          irq_allowed <= value[0];
        end
      end
      if (is_tick) begin
        if (vblank) begin
          line_counter <= 9'd0;
        end else begin
          if (fire) begin
            irq_armed <= 1'b0;
          end
          if (line_counter != cbm_pkg::COUNTER_MAX) begin
            line_counter <= line_counter + 9'd1;
          end
        end
      end
    end
  end

endmodule

>>> rtl/cbm_lookup.sv
// CPU and PPU address to ROM offset translation.
// Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_lookup (
  input  cbm_pkg::op_t                     op,
  input  logic [15:0]                      address,
  input  cbm_pkg::bank_state_t             banks,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]   prg_pages_log2,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]   chr_pages_log2,
  output logic [cbm_pkg::OFFSET_W-1:0]     offset,
  output logic                             offset_ok
);

  logic [7:0] prg_bank, chr_bank, prg_m, chr_m;

  assign prg_m = cbm_pkg::page_mask(prg_pages_log2);
  assign chr_m = cbm_pkg::page_mask(chr_pages_log2);

  // The top program window is fixed to the last page.
  assign prg_bank = (address[14:13] == 2'd3) ? cbm_pkg::FIXED_BANK
                                             : banks.prg[address[14:13]];
  assign chr_bank = banks.chr[address[12:10]];

  always_comb begin
    offset    = '0;
    offset_ok = 1'b0;
    unique case (op)
      cbm_pkg::OP_CPU_LOOKUP: begin
        if (address[15]) begin
          offset    = {prg_bank & prg_m, address[12:0]};
          offset_ok = 1'b1;
        end
      end
      cbm_pkg::OP_PPU_LOOKUP: begin
        offset    = {3'd0, chr_bank & chr_m, address[9:0]};
        offset_ok = 1'b1;
      end
      default: begin
        offset    = '0;
        offset_ok = 1'b0;
      end
    endcase
  end

endmodule
